// ----- design/caption_distribution_packet_parser_top_assert.svh -----
// Assertion macros shared by the checker of the caption packet parser.
`ifndef CAPTION_DISTRIBUTION_PACKET_PARSER_TOP_ASSERT_SVH
`define CAPTION_DISTRIBUTION_PACKET_PARSER_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CDPP_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define CDPP_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/cdpp_pkg.sv -----
// Package of the caption packet parser: phases, codes and shared structs.
`default_nettype none
package cdpp_pkg;

	localparam logic [31:0] CDP_MAGIC = 32'h63636470;
	localparam logic [15:0] CDP_IDENT = 16'h9669;

	localparam logic [7:0] SEC_TIMECODE = 8'h71;
	localparam logic [7:0] SEC_CC_DATA  = 8'h72;
	localparam logic [7:0] SEC_SVC_INFO = 8'h73;
	localparam logic [7:0] SEC_FOOTER   = 8'h74;
	localparam logic [7:0] SEC_FUT_LO   = 8'h75;
	localparam logic [7:0] SEC_FUT_HI   = 8'hEF;
	localparam logic [7:0] SEC_PAD      = 8'hFF;

	localparam logic KIND_PAIR   = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	localparam logic [1:0] CHAN_608_F1 = 2'd0;
	localparam logic [1:0] CHAN_608_F2 = 2'd1;
	localparam logic [1:0] CHAN_708    = 2'd2;

	localparam logic [2:0] PREFIX_LAST_IDX = 3'd7;
	localparam logic [2:0] HEADER_LAST_IDX = 3'd6;
	localparam logic [2:0] TIMECODE_LAST   = 3'd4;
	localparam logic [2:0] FOOTER_LAST     = 3'd3;
	localparam logic [2:0] SVC_ENTRY_LAST  = 3'd7;

	typedef enum logic [3:0] {
		PH_START,
		PH_PREFIX,
		PH_HEADER,
		PH_SECTION,
		PH_TIMECODE,
		PH_CC_COUNT,
		PH_CC_TRIPLET,
		PH_SVC_COUNT,
		PH_SVC_ENTRY,
		PH_FOOTER,
		PH_FUT_LEN,
		PH_FUT_SKIP,
		PH_SKIP_REST
	} phase_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_of_packet;
	} item_t;

	typedef struct packed {
		logic       result_kind;
		logic [1:0] channel;
		logic [1:0] pair_type;
		logic [7:0] first_data;
		logic [7:0] second_data;
	} result_t;

endpackage
`default_nettype wire

// ----- design/cdpp_in_if.sv -----
// Request channel carrying packet bytes into the parser.
`default_nettype none
interface cdpp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_of_packet;

	modport source (output valid, packet_byte, last_of_packet, input ready);
	modport sink (input valid, packet_byte, last_of_packet, output ready);
endinterface
`default_nettype wire

// ----- design/cdpp_out_if.sv -----
// Request channel carrying caption byte pairs and reject results.
`default_nettype none
interface cdpp_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [1:0] channel;
	logic [1:0] pair_type;
	logic [7:0] first_data;
	logic [7:0] second_data;

	modport source (output valid, result_kind, channel, pair_type, first_data, second_data,
		input ready);
	modport sink (input valid, result_kind, channel, pair_type, first_data, second_data,
		output ready);
endinterface
`default_nettype wire

// ----- design/cdpp_cfg_if.sv -----
// Configuration write channel carrying the prefix_present register.
`default_nettype none
interface cdpp_cfg_if;
	logic valid;
	logic ready;
	logic prefix_present;

	modport source (output valid, prefix_present, input ready);
	modport sink (input valid, prefix_present, output ready);
endinterface
`default_nettype wire

// ----- design/cdpp_in_stage.sv -----
// Input register stage: holds one accepted byte until the parser takes it.
`default_nettype none
module cdpp_in_stage (
	input  wire              clk,
	input  wire              arst_n,
	cdpp_in_if.sink          packet,
	input  wire              advance,
	output cdpp_pkg::item_t  item_s1,
	output logic             valid_s1
);
	import cdpp_pkg::*;

	// A new request is taken when the stage is empty or drains this cycle.
	assign packet.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (packet.ready) begin
			valid_s1 <= packet.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (packet.valid && packet.ready) begin
			item_s1.packet_byte    <= packet.packet_byte;
			item_s1.last_of_packet <= packet.last_of_packet;
		end
	end

endmodule
`default_nettype wire

// ----- design/cdpp_parser.sv -----
// Packet parser: the per-byte state update and the result it produces.
`default_nettype none
module cdpp_parser (
	input  wire                clk,
	input  wire                arst_n,
	cdpp_cfg_if.sink           cfg,
	input  wire                step,
	input  cdpp_pkg::item_t    item_s1,
	output logic               res_valid,
	output cdpp_pkg::result_t  res
);
	import cdpp_pkg::*;

	logic        prefix_present_q;
	phase_t      phase_q, phase_d;
	logic [7:0]  bis_q, bis_d;
	logic [4:0]  pairs_q, pairs_d;
	logic [3:0]  svcs_q, svcs_d;
	logic [2:0]  vt_q, vt_d;
	logic [7:0]  held_q, held_d;
	logic [31:0] word_q, word_d;
	logic        accepted_q, accepted_d;
	logic        rejected_q, rejected_d;
	logic        emit, reject;
	logic [7:0]  b;
	logic [4:0]  pairs_dec;
	logic [3:0]  svcs_dec;
	logic [7:0]  bis_dec;

	assign cfg.ready = 1'b1;
	assign b         = item_s1.packet_byte;
	assign pairs_dec = pairs_q - 5'd1;
	assign svcs_dec  = svcs_q - 4'd1;
	assign bis_dec   = bis_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_present_q <= 1'b0;
		end else if (cfg.valid) begin
			prefix_present_q <= cfg.prefix_present;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		bis_d      = bis_q;
		pairs_d    = pairs_q;
		svcs_d     = svcs_q;
		vt_d       = vt_q;
		held_d     = held_q;
		word_d     = word_q;
		accepted_d = accepted_q;
		rejected_d = rejected_q;
		emit       = 1'b0;
		reject     = 1'b0;
		res        = '0;

		if (!rejected_q) begin
			// The first byte of a packet picks its start from the register.
			if (phase_q == PH_START) begin
				phase_d = prefix_present_q ? PH_PREFIX : PH_HEADER;
				bis_d   = '0;
				word_d  = '0;
			end

			case (phase_d)
				PH_PREFIX: begin
					word_d = {word_d[23:0], b};
					if (bis_d[2:0] >= PREFIX_LAST_IDX) begin
						if (word_d != CDP_MAGIC) begin
							reject = 1'b1;
						end else begin
							phase_d = PH_HEADER;
							bis_d   = '0;
							word_d  = '0;
						end
					end else begin
						bis_d = bis_d + 8'd1;
					end
				end
				PH_HEADER: begin
					if (bis_d < 8'd2) begin
						word_d = {16'd0, word_d[7:0], b};
					end
					if (bis_d >= {5'd0, HEADER_LAST_IDX}) begin
						if (!accepted_q) begin
							if (word_d[15:0] != CDP_IDENT) begin
								reject = 1'b1;
							end else begin
								accepted_d = 1'b1;
							end
						end
						phase_d = PH_SECTION;
						bis_d   = '0;
					end else begin
						bis_d = bis_d + 8'd1;
					end
				end
				PH_SECTION: begin
					bis_d = '0;
					case (b) inside
						SEC_TIMECODE:             phase_d = PH_TIMECODE;
						SEC_CC_DATA:              phase_d = PH_CC_COUNT;
						SEC_SVC_INFO:             phase_d = PH_SVC_COUNT;
						SEC_FOOTER:               phase_d = PH_FOOTER;
						SEC_PAD:                  phase_d = PH_SECTION;
						[SEC_FUT_LO:SEC_FUT_HI]:  phase_d = PH_FUT_LEN;
						default:                  phase_d = PH_SKIP_REST;
					endcase
				end
				PH_TIMECODE: begin
					bis_d = bis_q + 8'd1;
					if (bis_d >= {5'd0, TIMECODE_LAST}) begin
						phase_d = PH_SECTION;
						bis_d   = '0;
					end
				end
				PH_FOOTER: begin
					bis_d = bis_q + 8'd1;
					if (bis_d >= {5'd0, FOOTER_LAST}) begin
						phase_d = PH_SECTION;
						bis_d   = '0;
					end
				end
				PH_CC_COUNT: begin
					pairs_d = b[4:0];
					bis_d   = '0;
					phase_d = (b[4:0] != 5'd0) ? PH_CC_TRIPLET : PH_SECTION;
				end
				PH_CC_TRIPLET: begin
					if (bis_q == 8'd0) begin
						vt_d  = b[2:0];
						bis_d = 8'd1;
					end else if (bis_q == 8'd1) begin
						held_d = b;
						bis_d  = 8'd2;
					end else begin
						emit              = vt_q[2];
						res.result_kind   = KIND_PAIR;
						res.channel       = vt_q[1] ? CHAN_708 :
							(vt_q[0] ? CHAN_608_F2 : CHAN_608_F1);
						res.pair_type     = vt_q[1:0];
						res.first_data    = held_q;
						res.second_data   = b;
						bis_d             = '0;
						pairs_d           = pairs_dec;
						if (pairs_dec == 5'd0) begin
							phase_d = PH_SECTION;
						end
					end
				end
				PH_SVC_COUNT: begin
					svcs_d  = b[3:0];
					bis_d   = '0;
					phase_d = (b[3:0] != 4'd0) ? PH_SVC_ENTRY : PH_SECTION;
				end
				PH_SVC_ENTRY: begin
					bis_d = bis_q + 8'd1;
					if (bis_d >= {5'd0, SVC_ENTRY_LAST}) begin
						bis_d  = '0;
						svcs_d = svcs_dec;
						if (svcs_dec == 4'd0) begin
							phase_d = PH_SECTION;
						end
					end
				end
				PH_FUT_LEN: begin
					bis_d   = b;
					phase_d = (b != 8'd0) ? PH_FUT_SKIP : PH_SECTION;
				end
				PH_FUT_SKIP: begin
					bis_d = bis_dec;
					if (bis_dec == 8'd0) begin
						phase_d = PH_SECTION;
					end
				end
				default: begin
				end
			endcase

			if (reject) begin
				rejected_d = 1'b1;
				emit       = 1'b1;
				res        = '0;
				res.result_kind = KIND_REJECT;
			end else if (item_s1.last_of_packet) begin
				phase_d = PH_START;
				bis_d   = '0;
				pairs_d = '0;
				svcs_d  = '0;
				vt_d    = '0;
				held_d  = '0;
				word_d  = '0;
			end
		end
	end

	assign res_valid = step && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			bis_q      <= '0;
			pairs_q    <= '0;
			svcs_q     <= '0;
			vt_q       <= '0;
			held_q     <= '0;
			word_q     <= '0;
			accepted_q <= 1'b0;
			rejected_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			bis_q      <= bis_d;
			pairs_q    <= pairs_d;
			svcs_q     <= svcs_d;
			vt_q       <= vt_d;
			held_q     <= held_d;
			word_q     <= word_d;
			accepted_q <= accepted_d;
			rejected_q <= rejected_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/cdpp_out_reg.sv -----
// Result register: holds one result until the receiver takes it.
`default_nettype none
module cdpp_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  cdpp_pkg::result_t  res,
	output logic               free,
	cdpp_out_if.source         result
);
	import cdpp_pkg::*;

	result_t res_q;
	logic    valid_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign result.valid       = valid_q;
	assign result.result_kind = res_q.result_kind;
	assign result.channel     = res_q.channel;
	assign result.pair_type   = res_q.pair_type;
	assign result.first_data  = res_q.first_data;
	assign result.second_data = res_q.second_data;

endmodule
`default_nettype wire

// ----- design/caption_distribution_packet_parser_top.sv -----
// Caption distribution packet parser, top level.
//
// packet: one packet byte per request, with last_of_packet on the final byte.
// result: one request per valid cc triplet (channel, type and its two data
//   bytes), or a single reject request when the magic or identifier is wrong.
// cfg: writes prefix_present; always ready, write only while the block is idle.
// A byte is held in the input register and is then parsed into the result
// register when that is free. One byte is accepted every cycle while the
// result register is not stalled; the parse of a byte is a single
// combinational update of the packet state between the two registers.
// If the receiver stalls, the result register holds its request, the input
// register fills, and packet.ready drops until the result is taken.
// Reset empties both registers, clears prefix_present and returns the parser
// to the start of a packet with no identifier yet accepted. After a reject,
// all further bytes are taken and dropped until the next reset.
`default_nettype none
module caption_distribution_packet_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	cdpp_in_if.sink     packet,
	cdpp_out_if.source  result,
	cdpp_cfg_if.sink    cfg
);
	import cdpp_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    out_free;
	logic    advance;
	logic    res_valid;
	result_t res;

	assign advance = valid_s1 && out_free;

	cdpp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.packet   (packet),
		.advance  (advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	cdpp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	cdpp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

endmodule
`default_nettype wire

// ----- design/cdpp_checker.sv -----
// Port-level checker for the caption packet parser, bound to the top level.
`default_nettype none
`include "caption_distribution_packet_parser_top_assert.svh"
module cdpp_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_ready,
	input wire       result_kind,
	input wire [1:0] channel,
	input wire [1:0] pair_type,
	input wire [7:0] first_data,
	input wire [7:0] second_data
);
	import cdpp_pkg::*;

	// A stalled result request stays up until it is taken.
	`CDPP_ASSERT_CLK(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

	`CDPP_ASSERT_RST(a_reset_empty, !arst_n |-> !res_valid, "result valid during reset")

	// A reject is the last result the block gives until the next reset.
	`CDPP_ASSERT_CLK(a_reject_final, res_valid && res_ready && result_kind == KIND_REJECT |=> !res_valid, "result after reject")

	`CDPP_ASSERT_CLK(a_reject_zero, res_valid && result_kind == KIND_REJECT |-> channel == 2'd0 && pair_type == 2'd0 && first_data == 8'd0 && second_data == 8'd0, "reject carries payload")

	`CDPP_ASSERT_CLK(a_channel_map, res_valid && result_kind == KIND_PAIR |-> (pair_type[1] && channel == CHAN_708) || (!pair_type[1] && channel == {1'b0, pair_type[0]}), "channel does not match type")

endmodule

bind caption_distribution_packet_parser_top cdpp_checker u_cdpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.result_kind (result.result_kind),
	.channel     (result.channel),
	.pair_type   (result.pair_type),
	.first_data  (result.first_data),
	.second_data (result.second_data)
);
`default_nettype wire
